// ===== rtl/rv32i_execute_subset_macros.svh =====
// assertion macros for the rv32i execute subset block
// no dependencies; included by files that carry concurrent assertions
`ifndef RV32I_EXECUTE_SUBSET_MACROS_SVH
`define RV32I_EXECUTE_SUBSET_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RVXS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RVXS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rvxs_pkg.sv =====
// shared types and constants of the rv32i execute subset block
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps
`default_nettype none

package rvxs_pkg;

	localparam int unsigned MEM_BYTES_DEF = 4096;
	localparam int unsigned NREGS         = 32;
	localparam int unsigned XLEN          = 32;

	// item kinds
	localparam logic ITEM_EXEC    = 1'b0;
	localparam logic ITEM_PRELOAD = 1'b1;

	// major opcodes
	typedef logic [6:0] opc_t;
	localparam opc_t OPC_LUI    = 7'h37;
	localparam opc_t OPC_AUIPC  = 7'h17;
	localparam opc_t OPC_JAL    = 7'h6F;
	localparam opc_t OPC_JALR   = 7'h67;
	localparam opc_t OPC_BRANCH = 7'h63;
	localparam opc_t OPC_LOAD   = 7'h03;
	localparam opc_t OPC_OPIMM  = 7'h13;

	// funct3 codes
	typedef logic [2:0] f3_t;
	localparam f3_t F3_ZERO = 3'd0;
	localparam f3_t F3_BEQ  = 3'd0;
	localparam f3_t F3_BNE  = 3'd1;
	localparam f3_t F3_BLT  = 3'd4;
	localparam f3_t F3_BGE  = 3'd5;
	localparam f3_t F3_BLTU = 3'd6;
	localparam f3_t F3_BGEU = 3'd7;
	localparam f3_t F3_LB   = 3'd0;
	localparam f3_t F3_LH   = 3'd1;
	localparam f3_t F3_LW   = 3'd2;
	localparam f3_t F3_LBU  = 3'd4;
	localparam f3_t F3_LHU  = 3'd5;

	// jalr target clears bit 0
	localparam logic [XLEN-1:0] JALR_MASK = ~32'd1;

	// input word
	typedef struct packed {
		logic        opcode;
		logic [31:0] instruction_word;
		logic [11:0] preload_address;
		logic [7:0]  preload_byte;
	} rvxs_req_t;

	// result word
	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_written;
		logic [4:0]  dest_index;
		logic [31:0] dest_value;
		logic        illegal;
	} rvxs_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/rvxs_chan_if.sv =====
// valid/ready channel carrying one word of payload type T
// no dependencies; payload types come from rvxs_pkg at instantiation
`timescale 1ns / 1ps
`default_nettype none

interface rvxs_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rvxs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies; read during write to the same entry returns old data
`timescale 1ns / 1ps
`default_nettype none

module rvxs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rv32i_execute_subset.sv =====
// rv32i execute subset: pc, register file and byte data memory in rams
// depends on rvxs_pkg, rvxs_chan_if and rvxs_ram
//
//   channel  dir  payload     handshake
//   req      in   rvxs_req_t  valid/ready, taken when both high
//   rsp      out  rvxs_rsp_t  valid/ready, taken when both high
//
// one word per cycle sustained while rsp.ready stays high; each word is registered in the
// decode stage, then in the write back stage, where its result is valid
// (register file ram read, then data memory ram read for loads, then write back)
// reset clears the pc and the register valid bits; data memory is not cleared
// rsp.ready low holds the result stage, the decode stage fills, then req.ready drops
// MEM_BYTES must be a power of two; the memory is split into four byte lanes
`timescale 1ns / 1ps
`default_nettype none

module rv32i_execute_subset
	import rvxs_pkg::*;
#(
	parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rvxs_chan_if.sink   req,
	rvxs_chan_if.source rsp
);

	localparam int unsigned AW   = $clog2(MEM_BYTES);
	localparam int unsigned ROWS = MEM_BYTES / 4;
	localparam int unsigned RW   = $clog2(ROWS);

	function automatic logic [31:0] imm_i(input logic [31:0] w);
		return {{20{w[31]}}, w[31:20]};
	endfunction

	function automatic logic [31:0] imm_b(input logic [31:0] w);
		return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
	endfunction

	function automatic logic [31:0] imm_j(input logic [31:0] w);
		return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
	endfunction

	// handshake and stage control
	logic v_s1, v_s2;
	logic s2_free, s1_go, s2_go, req_fire;

	assign s2_free   = !v_s2 || rsp.ready;
	assign s2_go     = v_s2 && rsp.ready;
	assign s1_go     = v_s1 && s2_free;
	assign req.ready = !v_s1 || s2_free;
	assign req_fire  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
		end
	end

	// register file: two read copies, valid bits give the reset value
	logic [NREGS-1:0] rf_vld_q;
	logic [XLEN-1:0]  rf_a_rdata, rf_b_rdata;
	logic             rf_we;
	logic [4:0]       rd_s2;
	logic [XLEN-1:0]  dval_s2;
	logic             wr_s2;

	assign rf_we = s2_go && wr_s2;

	rvxs_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rd_s2),
		.wdata (dval_s2),
		.re    (req_fire),
		.raddr (req.data.instruction_word[19:15]),
		.rdata (rf_a_rdata)
	);

	rvxs_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rd_s2),
		.wdata (dval_s2),
		.re    (req_fire),
		.raddr (req.data.instruction_word[24:20]),
		.rdata (rf_b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (rf_we) begin
			rf_vld_q[rd_s2] <= 1'b1;
		end
	end

	// last register write, forwarded to a read taken on the same edge
	logic            lw_vld_q;
	logic [4:0]      lw_idx_q;
	logic [XLEN-1:0] lw_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_vld_q <= 1'b0;
		end else if (rf_we) begin
			lw_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			lw_idx_q <= rd_s2;
			lw_val_q <= dval_s2;
		end
	end

	// decode stage registers
	rvxs_req_t word_s1;
	logic      rs1_ok_s1, rs2_ok_s1;

	always_ff @(posedge clk) begin
		if (req_fire) begin
			word_s1   <= req.data;
			rs1_ok_s1 <= rf_vld_q[req.data.instruction_word[19:15]];
			rs2_ok_s1 <= rf_vld_q[req.data.instruction_word[24:20]];
		end
	end

	// operand selection with forwarding from write back and last write
	logic [31:0]     w_s1;
	logic [4:0]      rs1_s1, rs2_s1, rdi_s1;
	f3_t             f3_s1;
	logic [XLEN-1:0] opa, opb;

	assign w_s1   = word_s1.instruction_word;
	assign rs1_s1 = w_s1[19:15];
	assign rs2_s1 = w_s1[24:20];
	assign rdi_s1 = w_s1[11:7];
	assign f3_s1  = w_s1[14:12];

	always_comb begin
		opa = rs1_ok_s1 ? rf_a_rdata : '0;
		opb = rs2_ok_s1 ? rf_b_rdata : '0;
		if (lw_vld_q && lw_idx_q == rs1_s1) begin
			opa = lw_val_q;
		end
		if (lw_vld_q && lw_idx_q == rs2_s1) begin
			opb = lw_val_q;
		end
		if (v_s2 && wr_s2 && rd_s2 == rs1_s1) begin
			opa = dval_s2;
		end
		if (v_s2 && wr_s2 && rd_s2 == rs2_s1) begin
			opb = dval_s2;
		end
	end

	// execute: next pc, destination value, legality
	logic [XLEN-1:0] pc_q;
	logic [XLEN-1:0] nxt, val, ld_sum;
	logic            ill, wrt, is_ld, take, wr;

	assign ld_sum = opa + imm_i(w_s1);

	always_comb begin
		ill   = 1'b0;
		wrt   = 1'b0;
		is_ld = 1'b0;
		take  = 1'b0;
		val   = '0;
		nxt   = pc_q + 32'd4;
		if (word_s1.opcode == ITEM_PRELOAD) begin
			nxt = pc_q;
		end else begin
			unique case (w_s1[6:0])
				OPC_LUI: begin
					val = {w_s1[31:12], 12'b0};
					wrt = 1'b1;
				end
				OPC_AUIPC: begin
					val = pc_q + {w_s1[31:12], 12'b0};
					wrt = 1'b1;
				end
				OPC_JAL: begin
					val = pc_q + 32'd4;
					wrt = 1'b1;
					nxt = pc_q + imm_j(w_s1);
				end
				OPC_JALR: begin
					if (f3_s1 != F3_ZERO) begin
						ill = 1'b1;
					end else begin
						val = pc_q + 32'd4;
						wrt = 1'b1;
						nxt = ld_sum & JALR_MASK;
					end
				end
				OPC_BRANCH: begin
					unique case (f3_s1)
						F3_BEQ:  take = opa == opb;
						F3_BNE:  take = opa != opb;
						F3_BLT:  take = $signed(opa) < $signed(opb);
						F3_BGE:  take = $signed(opa) >= $signed(opb);
						F3_BLTU: take = opa < opb;
						F3_BGEU: take = opa >= opb;
						default: ill = 1'b1;
					endcase
					if (take) begin
						nxt = pc_q + imm_b(w_s1);
					end
				end
				OPC_LOAD: begin
					unique case (f3_s1) inside
						F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU: begin
							is_ld = 1'b1;
							wrt   = 1'b1;
						end
						default: ill = 1'b1;
					endcase
				end
				OPC_OPIMM: begin
					if (f3_s1 != F3_ZERO) begin
						ill = 1'b1;
					end else begin
						val = ld_sum;
						wrt = 1'b1;
					end
				end
				default: ill = 1'b1;
			endcase
			if (ill) begin
				nxt = pc_q;
			end
		end
	end

	assign wr = wrt && !ill && (rdi_s1 != 5'd0) && (word_s1.opcode == ITEM_EXEC);

	// program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (s1_go) begin
			pc_q <= nxt;
		end
	end

	// data memory: four byte lanes, lane j holds bytes whose address ends in j
	logic [AW-1:0] ld_addr;
	logic [31:0]   pa_ext;
	logic [AW-1:0] pa;
	logic [7:0]    lane_rdata [4];

	assign ld_addr = ld_sum[AW-1:0];
	assign pa_ext  = 32'(word_s1.preload_address);
	assign pa      = pa_ext[AW-1:0];

	for (genvar j = 0; j < 4; j++) begin : g_lane
		logic [1:0]    ofs;
		logic [AW-1:0] baddr;
		logic          we;

		// byte of the load that falls in this lane, with wrap
		assign ofs   = 2'(j) - ld_addr[1:0];
		assign baddr = ld_addr + AW'(ofs);
		assign we    = s1_go && (word_s1.opcode == ITEM_PRELOAD) && (pa[1:0] == 2'(j));

		rvxs_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
			.clk   (clk),
			.we    (we),
			.waddr (pa[AW-1:2]),
			.wdata (word_s1.preload_byte),
			.re    (s1_go && is_ld),
			.raddr (baddr[AW-1:AW-RW]),
			.rdata (lane_rdata[j])
		);
	end

	// write back stage registers
	logic [XLEN-1:0] nxt_s2, val_s2;
	logic            ld_s2, ill_s2;
	f3_t             f3_s2;
	logic [1:0]      a10_s2;

	always_ff @(posedge clk) begin
		if (s1_go) begin
			nxt_s2 <= nxt;
			wr_s2  <= wr;
			rd_s2  <= wr ? rdi_s1 : 5'd0;
			val_s2 <= val;
			ld_s2  <= is_ld;
			ill_s2 <= ill && (word_s1.opcode == ITEM_EXEC);
			f3_s2  <= f3_s1;
			a10_s2 <= ld_addr[1:0];
		end
	end

	// load alignment and extension
	logic [7:0]      b0, b1, b2, b3;
	logic [XLEN-1:0] ld_val;

	assign b0 = lane_rdata[a10_s2];
	assign b1 = lane_rdata[a10_s2 + 2'd1];
	assign b2 = lane_rdata[a10_s2 + 2'd2];
	assign b3 = lane_rdata[a10_s2 + 2'd3];

	always_comb begin
		unique case (f3_s2)
			F3_LB:   ld_val = {{24{b0[7]}}, b0};
			F3_LH:   ld_val = {{16{b1[7]}}, b1, b0};
			F3_LW:   ld_val = {b3, b2, b1, b0};
			F3_LBU:  ld_val = {24'd0, b0};
			F3_LHU:  ld_val = {16'd0, b1, b0};
			default: ld_val = '0;
		endcase
	end

	assign dval_s2 = ld_s2 ? ld_val : val_s2;

	// result word
	assign rsp.valid            = v_s2;
	assign rsp.data.next_pc     = nxt_s2;
	assign rsp.data.reg_written = wr_s2;
	assign rsp.data.dest_index  = rd_s2;
	assign rsp.data.dest_value  = wr_s2 ? dval_s2 : '0;
	assign rsp.data.illegal     = ill_s2;

endmodule

`default_nettype wire

// ===== rtl/rvxs_checker.sv =====
// port-level checker for the rv32i execute subset block, bound to the top level
// depends on rvxs_pkg and rv32i_execute_subset_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "rv32i_execute_subset_macros.svh"

module rvxs_checker
	import rvxs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rvxs_rsp_t rsp_data
);

	logic        req_fire, rsp_fire;
	logic [2:0]  cnt_q;
	logic [31:0] last_pc_q;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// words in flight and pc of the last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			last_pc_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(req_fire) - 3'(rsp_fire);
			if (rsp_fire) begin
				last_pc_q <= rsp_data.next_pc;
			end
		end
	end

	`RVXS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result word dropped or changed while stalled")
	`RVXS_ASSERT_IMP(a_rsp_owed, clk, arst_n, rsp_valid, cnt_q != 3'd0, "result word without a pending input word")
	`RVXS_ASSERT_IMP(a_depth, clk, arst_n, 1'b1, cnt_q <= 3'd2, "more than two words in flight")
	`RVXS_ASSERT_IMP(a_illegal_pc, clk, arst_n, rsp_fire && rsp_data.illegal, rsp_data.next_pc == last_pc_q, "illegal instruction moved the pc")

endmodule

bind rv32i_execute_subset rvxs_checker u_rvxs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
